/* sv/arbb_pkg.sv */
// Shared types and constants for the affine rectangle bounding box block.
package arbb_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int PROD_W        = 2 * COORD_W;
    localparam int SUM_W         = PROD_W + 2;
    localparam int NUM_LANES     = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int IN_DATA_W     = 4 * COORD_W;
    localparam int OUT_DATA_W    = 4 * COORD_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_A   = 3'd0,
        REG_COEF_B   = 3'd1,
        REG_COEF_C   = 3'd2,
        REG_COEF_D   = 3'd3,
        REG_OFFSET_E = 3'd4,
        REG_OFFSET_F = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] coef_a;
        logic signed [COORD_W-1:0] coef_b;
        logic signed [COORD_W-1:0] coef_c;
        logic signed [COORD_W-1:0] coef_d;
        logic signed [COORD_W-1:0] offset_e;
        logic signed [COORD_W-1:0] offset_f;
    } matrix_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } pipe_en_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      sat;
    } lane_res_t;

endpackage

/* sv/arbb_lane.sv */
// One corner lane: multiply, accumulate with rounding, then saturate to 32 bits.
module arbb_lane #(
    parameter int FRAC_BITS = arbb_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  arbb_pkg::pipe_en_t                   en,
    input  arbb_pkg::matrix_t                    mtx,
    input  logic signed [arbb_pkg::COORD_W-1:0] pt_x,
    input  logic signed [arbb_pkg::COORD_W-1:0] pt_y,
    output arbb_pkg::lane_res_t                  res
);

    localparam int SW = arbb_pkg::SUM_W;
    localparam int PW = arbb_pkg::PROD_W;
    localparam int CW = arbb_pkg::COORD_W;
    localparam logic signed [SW-1:0] HALF    = (SW'(1) << FRAC_BITS) >> 1;
    localparam logic signed [SW-1:0] SAT_MAX = SW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [SW-1:0] SAT_MIN = -SAT_MAX - SW'(1);

    logic signed [PW-1:0] ax_reg, cy_reg, bx_reg, dy_reg;
    logic signed [PW-1:0] ax_next, cy_next, bx_next, dy_next;
    logic signed [SW-1:0] sx_reg, sy_reg, sx_next, sy_next;
    logic signed [SW-1:0] qx, qy;
    arbb_pkg::lane_res_t  res_reg, res_next;

    always_comb
    begin
        ax_next = mtx.coef_a * pt_x;
        cy_next = mtx.coef_c * pt_y;
        bx_next = mtx.coef_b * pt_x;
        dy_next = mtx.coef_d * pt_y;
    end

    always_comb
    begin
        sx_next = SW'(ax_reg) + SW'(cy_reg) + (SW'(mtx.offset_e) <<< FRAC_BITS) + HALF;
        sy_next = SW'(bx_reg) + SW'(dy_reg) + (SW'(mtx.offset_f) <<< FRAC_BITS) + HALF;
    end

    // floor to the output format, then clip
    always_comb
    begin
        qx = sx_reg >>> FRAC_BITS;
        qy = sy_reg >>> FRAC_BITS;
        res_next.sat = 1'b0;
        priority if (qx > SAT_MAX)
        begin
            res_next.x   = SAT_MAX[CW-1:0];
            res_next.sat = 1'b1;
        end
        else if (qx < SAT_MIN)
        begin
            res_next.x   = SAT_MIN[CW-1:0];
            res_next.sat = 1'b1;
        end
        else
        begin
            res_next.x = qx[CW-1:0];
        end
        priority if (qy > SAT_MAX)
        begin
            res_next.y   = SAT_MAX[CW-1:0];
            res_next.sat = 1'b1;
        end
        else if (qy < SAT_MIN)
        begin
            res_next.y   = SAT_MIN[CW-1:0];
            res_next.sat = 1'b1;
        end
        else
        begin
            res_next.y = qy[CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            ax_reg <= ax_next;
            cy_reg <= cy_next;
            bx_reg <= bx_next;
            dy_reg <= dy_next;
        end
        if (en.s2)
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
        if (en.s3)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

/* sv/arbb_merge.sv */
// Merge of the corner lanes into the bounding box, with the output register.
module arbb_merge (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  arbb_pkg::lane_res_t                  lanes [arbb_pkg::NUM_LANES],
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // box_min_x, box_min_y, box_max_x, box_max_y
    output logic [arbb_pkg::OUT_DATA_W-1:0]      m_tdata,
    // saturated
    output logic                                 m_tuser
);

    localparam int CW = arbb_pkg::COORD_W;

    logic                 valid_reg, valid_next;
    logic signed [CW-1:0] min_x, min_y, max_x, max_y;
    logic                 sat_any;
    logic [arbb_pkg::OUT_DATA_W-1:0] data_reg, data_next;
    logic                 user_reg, user_next;

    always_comb
    begin
        min_x   = lanes[0].x;
        max_x   = lanes[0].x;
        min_y   = lanes[0].y;
        max_y   = lanes[0].y;
        sat_any = lanes[0].sat;
        for (int i = 1; i < arbb_pkg::NUM_LANES; i++)
        begin
            if (lanes[i].x < min_x) min_x = lanes[i].x;
            if (lanes[i].x > max_x) max_x = lanes[i].x;
            if (lanes[i].y < min_y) min_y = lanes[i].y;
            if (lanes[i].y > max_y) max_y = lanes[i].y;
            sat_any = sat_any | lanes[i].sat;
        end
    end

    assign in_ready   = !valid_reg || m_tready;
    assign valid_next = in_ready ? in_valid : valid_reg;
    assign data_next  = {max_y, max_x, min_y, min_x};
    assign user_next  = sat_any;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
            user_reg <= user_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

/* sv/affine_rectangle_bounding_box.sv */
// Top level of the affine rectangle bounding box block.
// Maps the four corners of each rectangle through the 2D affine matrix held in the
// configuration registers and returns the bounding box of the mapped points, clipped
// to the signed 32-bit range with a saturation flag. One rectangle is taken per clock
// while the output is not stalled; a result passes through registers for the products,
// the rounded sums, the clipped corners and the box, the first of them loaded at the
// input transfer. The rate is set by four corner lanes of four 32x32 multipliers each,
// all working in the first stage. Write the matrix only while no rectangle is in
// flight.
module affine_rectangle_bounding_box #(
    parameter int FRAC_BITS = arbb_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wen,
    input  logic [arbb_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [arbb_pkg::COORD_W-1:0]         cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // left_x, bottom_y, right_x, top_y
    input  logic [arbb_pkg::IN_DATA_W-1:0]       s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // box_min_x, box_min_y, box_max_x, box_max_y
    output logic [arbb_pkg::OUT_DATA_W-1:0]      m_tdata,
    // saturated
    output logic                                 m_tuser
);

    localparam int CW = arbb_pkg::COORD_W;
    localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;

    arbb_pkg::matrix_t   mtx_reg;
    arbb_pkg::pipe_en_t  en;
    arbb_pkg::lane_res_t lanes [arbb_pkg::NUM_LANES];
    logic                v1_reg, v2_reg, v3_reg;
    logic                v1_next, v2_next, v3_next;
    logic                merge_ready;
    logic signed [CW-1:0] left_x, bottom_y, right_x, top_y;

    assign left_x   = s_tdata[CW-1:0];
    assign bottom_y = s_tdata[2*CW-1:CW];
    assign right_x  = s_tdata[3*CW-1:2*CW];
    assign top_y    = s_tdata[4*CW-1:3*CW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mtx_reg.coef_a   <= ONE;
            mtx_reg.coef_b   <= '0;
            mtx_reg.coef_c   <= '0;
            mtx_reg.coef_d   <= ONE;
            mtx_reg.offset_e <= '0;
            mtx_reg.offset_f <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_addr)
                arbb_pkg::REG_COEF_A:   mtx_reg.coef_a   <= cfg_wdata;
                arbb_pkg::REG_COEF_B:   mtx_reg.coef_b   <= cfg_wdata;
                arbb_pkg::REG_COEF_C:   mtx_reg.coef_c   <= cfg_wdata;
                arbb_pkg::REG_COEF_D:   mtx_reg.coef_d   <= cfg_wdata;
                arbb_pkg::REG_OFFSET_E: mtx_reg.offset_e <= cfg_wdata;
                arbb_pkg::REG_OFFSET_F: mtx_reg.offset_f <= cfg_wdata;
                default:                ;
            endcase
        end
    end

    // advance a stage when it is empty or the next one moves
    always_comb
    begin
        en.s3   = !v3_reg || merge_ready;
        en.s2   = !v2_reg || en.s3;
        en.s1   = !v1_reg || en.s2;
        v1_next = en.s1 ? s_tvalid : v1_reg;
        v2_next = en.s2 ? v1_reg : v2_reg;
        v3_next = en.s3 ? v2_reg : v3_reg;
    end

    assign s_tready = en.s1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    for (genvar i = 0; i < arbb_pkg::NUM_LANES; i++)
    begin : g_lane
        logic signed [CW-1:0] pt_x, pt_y;
        assign pt_x = (i / 2 == 1) ? right_x : left_x;
        assign pt_y = (i % 2 == 1) ? top_y : bottom_y;

        arbb_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk  (clk),
            .en   (en),
            .mtx  (mtx_reg),
            .pt_x (pt_x),
            .pt_y (pt_y),
            .res  (lanes[i])
        );
    end

    arbb_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v3_reg),
        .in_ready (merge_ready),
        .lanes    (lanes),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* bench/tb_affine_rectangle_bounding_box.sv */
// Testbench for the affine rectangle bounding box block: directed and random checks.
`timescale 1ns / 1ps

module tb_affine_rectangle_bounding_box;

    localparam int FRAC            = arbb_pkg::FRAC_BITS_DEF;
    localparam int PIPE_DEPTH      = 4;
    localparam int STALL_LIMIT     = 1000;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int NUM_REGS        = int'(arbb_pkg::REG_OFFSET_F) + 1;

    localparam logic [arbb_pkg::CFG_IDX_W-1:0] SPARE_IDX_LO = 3'd6;
    localparam logic [arbb_pkg::CFG_IDX_W-1:0] SPARE_IDX_HI = 3'd7;

    localparam logic signed [arbb_pkg::COORD_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [arbb_pkg::COORD_W-1:0] Q_MIN  = 32'sh8000_0000;
    localparam logic signed [arbb_pkg::COORD_W-1:0] Q_ONE  = 32'sd1 <<< FRAC;
    localparam logic signed [arbb_pkg::COORD_W-1:0] Q_HALF = Q_ONE >>> 1;
    localparam longint                              WIDE_CLAMP = 64'sd1 <<< 40;

    typedef struct {
        logic signed [arbb_pkg::COORD_W-1:0] left_x;
        logic signed [arbb_pkg::COORD_W-1:0] bottom_y;
        logic signed [arbb_pkg::COORD_W-1:0] right_x;
        logic signed [arbb_pkg::COORD_W-1:0] top_y;
    } rect_t;

    typedef struct {
        logic signed [arbb_pkg::COORD_W-1:0] min_x;
        logic signed [arbb_pkg::COORD_W-1:0] min_y;
        logic signed [arbb_pkg::COORD_W-1:0] max_x;
        logic signed [arbb_pkg::COORD_W-1:0] max_y;
        logic                                clipped;
    } box_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_wen;
    logic [arbb_pkg::CFG_IDX_W-1:0]  cfg_addr;
    logic [arbb_pkg::COORD_W-1:0]    cfg_wdata;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [arbb_pkg::IN_DATA_W-1:0]  s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [arbb_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            m_tuser;

    logic signed [arbb_pkg::COORD_W-1:0] matrix_model [NUM_REGS];
    box_t box_expected [$];

    bit src_idle_en;
    bit snk_stall_en;
    int errors;
    int rects_sent;
    int results_seen;
    int clipped_seen;
    int matrix_loads;
    int quiet_cycles;

    affine_rectangle_bounding_box dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // One mapped coordinate: m1*v1 + m2*v2 + off, rounded half up, clipped to 32 bits.
    function automatic logic signed [arbb_pkg::COORD_W-1:0] map_corner_coord(
        input longint m1, input longint v1, input longint m2, input longint v2,
        input longint off, output bit clip);
        longint p1;
        longint p2;
        longint s;
        longint carry;
        longint mask;
        longint half;
        mask  = (64'sd1 <<< FRAC) - 1;
        half  = (FRAC > 0) ? (64'sd1 <<< (FRAC - 1)) : 64'sd0;
        p1    = m1 * v1;
        p2    = m2 * v2;
        carry = ((p1 & mask) + (p2 & mask) + half) >>> FRAC;
        s     = (p1 >>> FRAC) + (p2 >>> FRAC);
        if (s > WIDE_CLAMP)
            s = WIDE_CLAMP;
        if (s < -WIDE_CLAMP)
            s = -WIDE_CLAMP;
        s    = s + off + carry;
        clip = 1'b0;
        if (s > longint'(Q_MAX))
        begin
            clip = 1'b1;
            return Q_MAX;
        end
        if (s < longint'(Q_MIN))
        begin
            clip = 1'b1;
            return Q_MIN;
        end
        return s[arbb_pkg::COORD_W-1:0];
    endfunction

    function automatic box_t predict_box(input rect_t r);
        logic signed [arbb_pkg::COORD_W-1:0] xs [2];
        logic signed [arbb_pkg::COORD_W-1:0] ys [2];
        logic signed [arbb_pkg::COORD_W-1:0] px;
        logic signed [arbb_pkg::COORD_W-1:0] py;
        bit   cx;
        bit   cy;
        box_t b;
        xs[0] = r.left_x;
        ys[0] = r.bottom_y;
        xs[1] = r.right_x;
        ys[1] = r.top_y;
        b.clipped = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                px = map_corner_coord(longint'(matrix_model[arbb_pkg::REG_COEF_A]),
                                      longint'(xs[i]),
                                      longint'(matrix_model[arbb_pkg::REG_COEF_C]),
                                      longint'(ys[j]),
                                      longint'(matrix_model[arbb_pkg::REG_OFFSET_E]), cx);
                py = map_corner_coord(longint'(matrix_model[arbb_pkg::REG_COEF_B]),
                                      longint'(xs[i]),
                                      longint'(matrix_model[arbb_pkg::REG_COEF_D]),
                                      longint'(ys[j]),
                                      longint'(matrix_model[arbb_pkg::REG_OFFSET_F]), cy);
                b.clipped = b.clipped | cx | cy;
                if ((i == 0 && j == 0) || px < b.min_x)
                    b.min_x = px;
                if ((i == 0 && j == 0) || py < b.min_y)
                    b.min_y = py;
                if ((i == 0 && j == 0) || px > b.max_x)
                    b.max_x = px;
                if ((i == 0 && j == 0) || py > b.max_y)
                    b.max_y = py;
            end
        end
        return b;
    endfunction

    function automatic logic [arbb_pkg::COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
            3:
            begin
                case ($urandom_range(0, 4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    3: return 32'd1;
                    default: return '1;
                endcase
            end
            default: return {16'($urandom_range(0, 32'h3FF)) - 16'h0200, 16'($urandom)};
        endcase
    endfunction

    function automatic logic [arbb_pkg::COORD_W-1:0] rand_coef();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return rand_coord();
            default: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
        endcase
    endfunction

    function automatic rect_t rand_rect();
        rect_t r;
        r.left_x   = rand_coord();
        r.bottom_y = rand_coord();
        r.right_x  = rand_coord();
        r.top_y    = rand_coord();
        return r;
    endfunction

    function automatic rect_t make_rect(input logic [arbb_pkg::COORD_W-1:0] lx,
                                        input logic [arbb_pkg::COORD_W-1:0] by,
                                        input logic [arbb_pkg::COORD_W-1:0] rx,
                                        input logic [arbb_pkg::COORD_W-1:0] ty);
        rect_t r;
        r.left_x   = lx;
        r.bottom_y = by;
        r.right_x  = rx;
        r.top_y    = ty;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [arbb_pkg::COORD_W-1:0] got,
                                   input logic [arbb_pkg::COORD_W-1:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        errors++;
    endtask

    task automatic check_field(input string what, input logic [arbb_pkg::COORD_W-1:0] got,
                               input logic [arbb_pkg::COORD_W-1:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_rect(input rect_t r);
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_tdata  = {r.top_y, r.right_x, r.bottom_y, r.left_x};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        box_expected.push_back(predict_box(r));
        rects_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (box_expected.size() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH) @(negedge clk);
    endtask

    task automatic write_reg(input logic [arbb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [arbb_pkg::COORD_W-1:0] val);
        cfg_wen   = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_wen = 1'b0;
        if (idx < NUM_REGS)
            matrix_model[idx] = val;
    endtask

    task automatic load_matrix(input logic [arbb_pkg::COORD_W-1:0] a,
                               input logic [arbb_pkg::COORD_W-1:0] b,
                               input logic [arbb_pkg::COORD_W-1:0] c,
                               input logic [arbb_pkg::COORD_W-1:0] d,
                               input logic [arbb_pkg::COORD_W-1:0] e,
                               input logic [arbb_pkg::COORD_W-1:0] f);
        wait_idle();
        write_reg(arbb_pkg::REG_COEF_A, a);
        write_reg(arbb_pkg::REG_COEF_B, b);
        write_reg(arbb_pkg::REG_COEF_C, c);
        write_reg(arbb_pkg::REG_COEF_D, d);
        write_reg(arbb_pkg::REG_OFFSET_E, e);
        write_reg(arbb_pkg::REG_OFFSET_F, f);
        matrix_loads++;
    endtask

    task automatic test_identity_extremes();
        send_rect(make_rect('0, '0, '0, '0));
        send_rect(make_rect(Q_MIN, Q_MIN, Q_MAX, Q_MAX));
        send_rect(make_rect(Q_MAX, Q_MAX, Q_MIN, Q_MIN));
        send_rect(make_rect(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555));
        send_rect(make_rect('1, '1, '1, '1));
    endtask

    task automatic test_spare_index();
        wait_idle();
        write_reg(SPARE_IDX_LO, 32'hDEAD_BEEF);
        write_reg(SPARE_IDX_HI, 32'h1234_5678);
        send_rect(rand_rect());
        send_rect(rand_rect());
    endtask

    task automatic test_rounding();
        load_matrix(Q_HALF, 0, Q_HALF, -Q_HALF, 0, 0);
        send_rect(make_rect(32'd1, 32'd1, -32'sd1, -32'sd1));
        send_rect(make_rect(32'd3, -32'sd3, -32'sd3, 32'd3));
        send_rect(make_rect(32'h0001_8001, 32'hFFFE_7FFF, 32'd5, -32'sd7));
    endtask

    task automatic test_corner_order();
        rect_t r;
        load_matrix(0, Q_ONE, -Q_ONE, 0, Q_ONE, -Q_ONE);
        repeat (2)
        begin
            r = rand_rect();
            send_rect(r);
            send_rect(make_rect(r.right_x, r.top_y, r.left_x, r.bottom_y));
        end
    endtask

    task automatic test_saturation();
        load_matrix(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        send_rect(make_rect(Q_MAX, Q_MAX, Q_MIN, Q_MIN));
        send_rect(make_rect('0, '0, '0, '0));
        send_rect(make_rect(32'd1, 32'd1, 32'd1, 32'd1));
        load_matrix(Q_ONE <<< 1, 0, 0, Q_ONE <<< 1, 0, 0);
        send_rect(make_rect(Q_MAX, Q_MIN, '0, '0));
        load_matrix(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_rect(make_rect(Q_MIN, Q_MAX, Q_MAX, Q_MIN));
        send_rect(make_rect('1, '1, 32'd1, 32'd1));
    endtask

    task automatic test_random_settings();
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: load_matrix(Q_ONE, 0, 0, Q_ONE, rand_coord(), rand_coord());
                1: load_matrix(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
                2: load_matrix(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
                3: load_matrix(0, rand_coef(), rand_coef(), 0, rand_coord(), rand_coord());
                4: load_matrix($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                default: load_matrix(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                                     rand_coord(), rand_coord());
            endcase
            src_idle_en  = (ph < PHASES - 2);
            snk_stall_en = (ph < PHASES - 2);
            repeat (ITEMS_PER_PHASE) send_rect(rand_rect());
        end
    endtask

    // Sink side: hold tready low for random bursts.
    initial
    begin
        int hold;
        hold     = 0;
        m_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (hold == 0 && snk_stall_en && $urandom_range(0, 3) == 0)
                hold = $urandom_range(1, 5);
            m_tready = (hold == 0);
            if (hold > 0)
                hold--;
        end
    end

    always @(posedge clk)
    begin
        box_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (box_expected.size() == 0)
                report_mismatch("result with none expected", m_tdata[arbb_pkg::COORD_W-1:0], '0);
            else
            begin
                want = box_expected.pop_front();
                check_field("box_min_x", m_tdata[0*arbb_pkg::COORD_W +: arbb_pkg::COORD_W],
                            want.min_x);
                check_field("box_min_y", m_tdata[1*arbb_pkg::COORD_W +: arbb_pkg::COORD_W],
                            want.min_y);
                check_field("box_max_x", m_tdata[2*arbb_pkg::COORD_W +: arbb_pkg::COORD_W],
                            want.max_x);
                check_field("box_max_y", m_tdata[3*arbb_pkg::COORD_W +: arbb_pkg::COORD_W],
                            want.max_y);
                check_field("saturated", 32'(m_tuser), 32'(want.clipped));
            end
            results_seen++;
            if (m_tuser)
                clipped_seen++;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_wen      = 1'b0;
        cfg_addr     = arbb_pkg::REG_COEF_A;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        src_idle_en  = 1'b1;
        snk_stall_en = 1'b1;
        errors       = 0;
        rects_sent   = 0;
        results_seen = 0;
        clipped_seen = 0;
        matrix_loads = 0;
        quiet_cycles = 0;
        matrix_model[arbb_pkg::REG_COEF_A]   = Q_ONE;
        matrix_model[arbb_pkg::REG_COEF_B]   = '0;
        matrix_model[arbb_pkg::REG_COEF_C]   = '0;
        matrix_model[arbb_pkg::REG_COEF_D]   = Q_ONE;
        matrix_model[arbb_pkg::REG_OFFSET_E] = '0;
        matrix_model[arbb_pkg::REG_OFFSET_F] = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_identity_extremes();
        test_spare_index();
        test_rounding();
        test_corner_order();
        test_saturation();
        test_random_settings();
        wait_idle();

        $display("Checked %0d rectangles (%0d results) under the reset matrix and %0d loaded ones;",
                 rects_sent, results_seen, matrix_loads);
        $display("%0d boxes came back clipped, spare register indexes were written too.",
                 clipped_seen);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
